>>> rtl/wpp_pkg.sv
package wpp_pkg;

	// parse phases, one per header field, then data and idle
	typedef enum logic [3:0] {
		PH_RIFF, PH_RIFF_SIZE, PH_WAVE, PH_FMT, PH_FMT_SIZE, PH_FORMAT, PH_CHANNELS,
		PH_RATE, PH_BYTE_RATE, PH_BLOCK, PH_BITS, PH_DATA_ID, PH_DATA_SIZE,
		PH_DATA, PH_IDLE
	} phase_t;

	// back end sequencer
	typedef enum logic [2:0] {
		BK_POP, BK_MUL, BK_CHK, BK_DIV, BK_FIN
	} back_state_t;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_SAMPLE = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [3:0] ERR_NONE       = 4'd0;
	localparam logic [3:0] ERR_RIFF       = 4'd1;
	localparam logic [3:0] ERR_WAVE       = 4'd2;
	localparam logic [3:0] ERR_FMT        = 4'd3;
	localparam logic [3:0] ERR_FORMAT     = 4'd4;
	localparam logic [3:0] ERR_CHANNELS   = 4'd5;
	localparam logic [3:0] ERR_RATE       = 4'd6;
	localparam logic [3:0] ERR_BYTE_RATE0 = 4'd7;
	localparam logic [3:0] ERR_BLOCK0     = 4'd8;
	localparam logic [3:0] ERR_BITS0      = 4'd9;
	localparam logic [3:0] ERR_BLOCK      = 4'd10;
	localparam logic [3:0] ERR_BYTE_RATE  = 4'd11;
	localparam logic [3:0] ERR_DATA_ID    = 4'd12;
	localparam logic [3:0] ERR_MULTIPLE   = 4'd13;
	localparam logic [3:0] ERR_BITS       = 4'd14;

	localparam logic [31:0] ID_RIFF = 32'h4646_4952;
	localparam logic [31:0] ID_WAVE = 32'h4556_4157;
	localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
	localparam logic [31:0] ID_DATA = 32'h6174_6164;

	localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// one classified beat travelling from front to back
	typedef struct packed {
		logic        restart;
		logic        is_sample;
		phase_t      phase;
		logic [31:0] word;
		logic [15:0] channel;
		logic        frame_end;
	} q_entry_t;

	// header fields of two bytes
	function automatic logic is_short(phase_t ph);
		case (ph)
			PH_FORMAT, PH_CHANNELS, PH_BLOCK, PH_BITS: is_short = 1'b1;
			default:                                   is_short = 1'b0;
		endcase
	endfunction

endpackage

>>> rtl/wav_pcm_stream_parser.sv
// channel  direction  payload                                              handshake
// in       sink       data_byte, new_file                                  in_valid / in_stall
// out      source     result_kind, sample_value, channel_index, frame_end, out_valid / out_stall
//                     error_code, channel_count, sample_rate,
//                     sample_bits, frame_count
// One byte a cycle while the four-entry queue has room; data bytes stream at that rate.
// The end of a nonzero bit-depth field steps the back end through pop, multiply and compare.
// The data-size field runs a one-bit-a-cycle divider in the back end for frame count.
// Those stalls are absorbed by the queue until it fills, then in_stall rises.
// arst_n clears all control state; new_file restarts the parser at that byte.
module wav_pcm_stream_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               new_file,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         result_kind,
	output logic signed [31:0] sample_value,
	output logic [15:0]        channel_index,
	output logic               frame_end,
	output logic [3:0]         error_code,
	output logic [15:0]        channel_count,
	output logic [31:0]        sample_rate,
	output logic [5:0]         sample_bits,
	output logic [31:0]        frame_count
);

	logic              push, pop, full, empty;
	wpp_pkg::q_entry_t wr_entry, rd_entry;

	assign in_stall = full;

	wpp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_valid && !in_stall),
		.data_byte (data_byte),
		.new_file  (new_file),
		.push      (push),
		.entry     (wr_entry)
	);

	wpp_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_entry),
		.pop     (pop),
		.rd_data (rd_entry),
		.full    (full),
		.empty   (empty)
	);

	wpp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.entry         (rd_entry),
		.empty         (empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.sample_value  (sample_value),
		.channel_index (channel_index),
		.frame_end     (frame_end),
		.error_code    (error_code),
		.channel_count (channel_count),
		.sample_rate   (sample_rate),
		.sample_bits   (sample_bits),
		.frame_count   (frame_count)
	);

endmodule

>>> rtl/wpp_fifo.sv
module wpp_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wpp_pkg::q_entry_t  wr_data,
	input  logic               pop,
	output wpp_pkg::q_entry_t  rd_data,
	output logic               full,
	output logic               empty
);

	wpp_pkg::q_entry_t               mem_q [wpp_pkg::QUEUE_DEPTH];
	logic [wpp_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [wpp_pkg::QPTR_W:0]        count_q;

	assign full    = (count_q == (wpp_pkg::QPTR_W+1)'(wpp_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> !full) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue underflow");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && pop) |=> $stable(count_q)) else $error("fill level moved");

endmodule

>>> rtl/wpp_front.sv
module wpp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         data_byte,
	input  logic               new_file,
	output logic               push,
	output wpp_pkg::q_entry_t  entry
);

	wpp_pkg::phase_t phase_q, phase_n;
	logic [2:0]      cnt_q, cnt_n;
	logic [31:0]     shift_q, shift_n;
	logic [15:0]     chans_q, chans_n;
	logic [2:0]      nbytes_q, nbytes_n;
	logic [31:0]     left_q, left_n;
	logic [15:0]     cur_q, cur_n;
	logic            restart_q;
	logic [31:0]     v;
	logic            last_ch;

	// byte assembly, phase tracking and classification
	always_comb begin
		phase_n  = phase_q;
		cnt_n    = cnt_q;
		shift_n  = shift_q;
		chans_n  = chans_q;
		nbytes_n = nbytes_q;
		left_n   = left_q;
		cur_n    = cur_q;
		push     = 1'b0;
		entry    = '0;
		v        = '0;
		last_ch  = 1'b0;
		if (accept) begin
			if (new_file) begin
				phase_n  = wpp_pkg::PH_RIFF;
				cnt_n    = '0;
				shift_n  = '0;
				chans_n  = '0;
				nbytes_n = '0;
				left_n   = '0;
				cur_n    = '0;
			end
			entry.restart = restart_q | new_file;
			if (phase_n != wpp_pkg::PH_IDLE) begin
				shift_n = {data_byte, shift_n[31:8]};
				cnt_n   = cnt_n + 3'd1;
				if (phase_n == wpp_pkg::PH_DATA) begin
					left_n = left_n - 32'd1;
					if (cnt_n >= nbytes_n) begin
						last_ch         = ({1'b0, cur_n} + 17'd1) >= {1'b0, chans_n};
						push            = 1'b1;
						entry.is_sample = 1'b1;
						entry.phase     = wpp_pkg::PH_DATA;
						entry.word      = (nbytes_n == 3'd1) ? (shift_n ^ wpp_pkg::SIGN_FLIP)
						                                     : shift_n;
						entry.channel   = cur_n;
						entry.frame_end = last_ch;
						cur_n           = last_ch ? 16'd0 : cur_n + 16'd1;
						shift_n         = '0;
						cnt_n           = '0;
					end
					if (left_n == '0) phase_n = wpp_pkg::PH_IDLE;
				end else if (cnt_n >= (wpp_pkg::is_short(phase_n) ? 3'd2 : 3'd4)) begin
					v           = wpp_pkg::is_short(phase_n) ? {16'd0, shift_n[31:16]} : shift_n;
					push        = 1'b1;
					entry.phase = phase_n;
					entry.word  = v;
					shift_n     = '0;
					cnt_n       = '0;
					case (phase_n)
						wpp_pkg::PH_CHANNELS: begin
							chans_n = v[15:0];
							phase_n = wpp_pkg::PH_RATE;
						end
						wpp_pkg::PH_BITS: begin
							nbytes_n = v[5:3];
							phase_n  = wpp_pkg::PH_DATA_ID;
						end
						wpp_pkg::PH_DATA_SIZE: begin
							left_n  = v;
							cur_n   = '0;
							phase_n = (v == '0) ? wpp_pkg::PH_IDLE : wpp_pkg::PH_DATA;
						end
						default: begin
							phase_n = wpp_pkg::phase_t'(phase_n + 4'd1);
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= wpp_pkg::PH_RIFF;
			cnt_q     <= '0;
			shift_q   <= '0;
			chans_q   <= '0;
			nbytes_q  <= '0;
			left_q    <= '0;
			cur_q     <= '0;
			restart_q <= 1'b0;
		end else begin
			phase_q  <= phase_n;
			cnt_q    <= cnt_n;
			shift_q  <= shift_n;
			chans_q  <= chans_n;
			nbytes_q <= nbytes_n;
			left_q   <= left_n;
			cur_q    <= cur_n;
			// restart mark rides on the next queued beat
			if (push)                    restart_q <= 1'b0;
			else if (accept && new_file) restart_q <= 1'b1;
		end
	end

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !new_file && phase_q == wpp_pkg::PH_IDLE) |-> !push)
		else $error("beat queued while idle");
	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == wpp_pkg::PH_DATA && nbytes_q != '0) |-> cnt_q < nbytes_q)
		else $error("sample byte count overran");
	a_restart_clear: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !restart_q || $past(new_file && !push))
		else $error("restart mark not cleared");

endmodule

>>> rtl/wpp_back.sv
module wpp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  wpp_pkg::q_entry_t  entry,
	input  logic               empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         result_kind,
	output logic signed [31:0] sample_value,
	output logic [15:0]        channel_index,
	output logic               frame_end,
	output logic [3:0]         error_code,
	output logic [15:0]        channel_count,
	output logic [31:0]        sample_rate,
	output logic [5:0]         sample_bits,
	output logic [31:0]        frame_count
);

	wpp_pkg::back_state_t state_q, state_n;
	logic        dead_q, dead_eff;
	logic [15:0] ch_q, block_q, bits_q;
	logic [31:0] rate_q, brate_q;
	logic [28:0] prod_blk_q;
	logic [31:0] prod_rate_q;
	logic [47:0] rate_full;
	logic [31:0] quo_q;
	logic [15:0] rem_q;
	logic [4:0]  cnt_q;
	logic [16:0] trial, trial_sub;
	logic        trial_ge;
	logic        can_out, live;
	logic        emit;
	logic [1:0]  emit_kind;
	logic [3:0]  emit_code;
	logic        bits_ok;

	assign can_out   = !out_valid || !out_stall;
	assign dead_eff  = entry.restart ? 1'b0 : dead_q;
	assign live      = pop && !dead_eff;
	assign rate_full = {16'd0, rate_q} * {32'd0, block_q};
	assign trial     = {rem_q, quo_q[31]};
	assign trial_sub = trial - {1'b0, block_q};
	assign trial_ge  = trial >= {1'b0, block_q};
	assign bits_ok   = (bits_q == 16'd8) || (bits_q == 16'd16) ||
	                   (bits_q == 16'd24) || (bits_q == 16'd32);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			wpp_pkg::BK_POP: begin
				if (live && !entry.is_sample) begin
					if (entry.phase == wpp_pkg::PH_BITS && entry.word[15:0] != '0)
						state_n = wpp_pkg::BK_MUL;
					else if (entry.phase == wpp_pkg::PH_DATA_SIZE)
						state_n = wpp_pkg::BK_DIV;
				end
			end
			wpp_pkg::BK_MUL: state_n = wpp_pkg::BK_CHK;
			wpp_pkg::BK_CHK: if (can_out) state_n = wpp_pkg::BK_POP;
			wpp_pkg::BK_DIV: if (cnt_q == 5'd31) state_n = wpp_pkg::BK_FIN;
			wpp_pkg::BK_FIN: if (can_out) state_n = wpp_pkg::BK_POP;
			default:         state_n = wpp_pkg::BK_POP;
		endcase
	end

	// checks and result selection
	always_comb begin
		pop       = 1'b0;
		emit      = 1'b0;
		emit_kind = wpp_pkg::KIND_ERROR;
		emit_code = wpp_pkg::ERR_NONE;
		case (state_q)
			wpp_pkg::BK_POP: begin
				pop = !empty && can_out;
				if (pop && !dead_eff) begin
					if (entry.is_sample) begin
						emit      = 1'b1;
						emit_kind = wpp_pkg::KIND_SAMPLE;
					end else begin
						case (entry.phase)
							wpp_pkg::PH_RIFF:
								if (entry.word != wpp_pkg::ID_RIFF) begin
									emit = 1'b1; emit_code = wpp_pkg::ERR_RIFF;
								end
							wpp_pkg::PH_WAVE:
								if (entry.word != wpp_pkg::ID_WAVE) begin
									emit = 1'b1; emit_code = wpp_pkg::ERR_WAVE;
								end
							wpp_pkg::PH_FMT:
								if (entry.word != wpp_pkg::ID_FMT) begin
									emit = 1'b1; emit_code = wpp_pkg::ERR_FMT;
								end
							wpp_pkg::PH_FORMAT:
								if (entry.word != 32'd1) begin
									emit = 1'b1; emit_code = wpp_pkg::ERR_FORMAT;
								end
							wpp_pkg::PH_CHANNELS:
								if (entry.word == '0) begin
									emit = 1'b1; emit_code = wpp_pkg::ERR_CHANNELS;
								end
							wpp_pkg::PH_RATE:
								if (entry.word == '0) begin
									emit = 1'b1; emit_code = wpp_pkg::ERR_RATE;
								end
							wpp_pkg::PH_BYTE_RATE:
								if (entry.word == '0) begin
									emit = 1'b1; emit_code = wpp_pkg::ERR_BYTE_RATE0;
								end
							wpp_pkg::PH_BLOCK:
								if (entry.word == '0) begin
									emit = 1'b1; emit_code = wpp_pkg::ERR_BLOCK0;
								end
							wpp_pkg::PH_BITS:
								if (entry.word == '0) begin
									emit = 1'b1; emit_code = wpp_pkg::ERR_BITS0;
								end
							wpp_pkg::PH_DATA_ID:
								if (entry.word != wpp_pkg::ID_DATA) begin
									emit = 1'b1; emit_code = wpp_pkg::ERR_DATA_ID;
								end
							default: emit = 1'b0;
						endcase
					end
				end
			end
			wpp_pkg::BK_CHK: begin
				if (can_out) begin
					if (prod_blk_q != {13'd0, block_q}) begin
						emit = 1'b1; emit_code = wpp_pkg::ERR_BLOCK;
					end else if (prod_rate_q != brate_q) begin
						emit = 1'b1; emit_code = wpp_pkg::ERR_BYTE_RATE;
					end
				end
			end
			wpp_pkg::BK_FIN: begin
				if (can_out) begin
					emit = 1'b1;
					if (rem_q != '0)  emit_code = wpp_pkg::ERR_MULTIPLE;
					else if (!bits_ok) emit_code = wpp_pkg::ERR_BITS;
					else               emit_kind = wpp_pkg::KIND_HEADER;
				end
			end
			default: pop = 1'b0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= wpp_pkg::BK_POP;
			dead_q    <= 1'b0;
			out_valid <= 1'b0;
			cnt_q     <= '0;
		end else begin
			state_q <= state_n;
			if (emit && emit_kind == wpp_pkg::KIND_ERROR) dead_q <= 1'b1;
			else if (pop && entry.restart)                dead_q <= 1'b0;
			if (emit)           out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (state_q == wpp_pkg::BK_DIV) cnt_q <= cnt_q + 5'd1;
			else                            cnt_q <= '0;
		end
	end

	// header fields, products, divider and result register
	always_ff @(posedge clk) begin
		if (live && !entry.is_sample) begin
			case (entry.phase)
				wpp_pkg::PH_CHANNELS:  ch_q    <= entry.word[15:0];
				wpp_pkg::PH_RATE:      rate_q  <= entry.word;
				wpp_pkg::PH_BYTE_RATE: brate_q <= entry.word;
				wpp_pkg::PH_BLOCK:     block_q <= entry.word[15:0];
				wpp_pkg::PH_BITS:      bits_q  <= entry.word[15:0];
				wpp_pkg::PH_DATA_SIZE: begin
					quo_q <= entry.word;
					rem_q <= '0;
				end
				default: ;
			endcase
		end
		if (state_q == wpp_pkg::BK_MUL) begin
			prod_blk_q  <= {16'd0, bits_q[15:3]} * {13'd0, ch_q};
			prod_rate_q <= rate_full[31:0];
		end
		if (state_q == wpp_pkg::BK_DIV) begin
			rem_q <= trial_ge ? trial_sub[15:0] : trial[15:0];
			quo_q <= {quo_q[30:0], trial_ge};
		end
		if (emit) begin
			result_kind   <= emit_kind;
			sample_value  <= (emit_kind == wpp_pkg::KIND_SAMPLE) ? entry.word : '0;
			channel_index <= (emit_kind == wpp_pkg::KIND_SAMPLE) ? entry.channel : '0;
			frame_end     <= (emit_kind == wpp_pkg::KIND_SAMPLE) ? entry.frame_end : 1'b0;
			error_code    <= emit_code;
			channel_count <= (emit_kind == wpp_pkg::KIND_HEADER) ? ch_q : '0;
			sample_rate   <= (emit_kind == wpp_pkg::KIND_HEADER) ? rate_q : '0;
			sample_bits   <= (emit_kind == wpp_pkg::KIND_HEADER) ? bits_q[5:0] : '0;
			frame_count   <= (emit_kind == wpp_pkg::KIND_HEADER) ? quo_q : '0;
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wpp_pkg::BK_DIV) |-> block_q != '0) else $error("divide by zero");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wpp_pkg::BK_DIV) |-> rem_q < block_q) else $error("remainder too large");
	a_err_latch: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_kind == wpp_pkg::KIND_ERROR) |=> dead_q) else $error("error not latched");
	a_pop_state: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == wpp_pkg::BK_POP) else $error("pop outside pop state");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         data_byte;
	logic               new_file;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         result_kind;
	logic signed [31:0] sample_value;
	logic [15:0]        channel_index;
	logic               frame_end;
	logic [3:0]         error_code;
	logic [15:0]        channel_count;
	logic [31:0]        sample_rate;
	logic [5:0]         sample_bits;
	logic [31:0]        frame_count;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] sample;
		logic [15:0] chan;
		logic        fend;
		logic [3:0]  err;
		logic [15:0] nchan;
		logic [31:0] rate;
		logic [5:0]  bits;
		logic [31:0] frames;
	} wav_result_t;

	wav_result_t pending_results[$];
	int          fail_count;
	bit          idle_on;

	// parser mirror
	wpp_pkg::phase_t mp_phase;
	logic [2:0]  mp_count;
	logic [31:0] mp_shift;
	logic [31:0] mp_chans, mp_rate, mp_brate, mp_block, mp_bits, mp_left, mp_cur;

	wav_pcm_stream_parser dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic mirror_clear();
		mp_phase = wpp_pkg::PH_RIFF;
		mp_count = '0;
		mp_shift = '0;
		mp_chans = '0; mp_rate = '0; mp_brate = '0; mp_block = '0;
		mp_bits = '0; mp_left = '0; mp_cur = '0;
	endtask

	function automatic wav_result_t err_result(logic [3:0] code);
		wav_result_t r;
		r = '0;
		r.kind = wpp_pkg::KIND_ERROR;
		r.err = code;
		return r;
	endfunction

	// advance the mirror by one byte; push any result it yields
	task automatic predict_byte(logic [7:0] b, logic nf);
		wav_result_t r;
		logic [31:0] v;
		int          len;
		logic [3:0]  code;
		logic [63:0] prod;
		if (nf) mirror_clear();
		if (mp_phase == wpp_pkg::PH_IDLE) return;
		mp_shift = {b, mp_shift[31:8]};
		mp_count = mp_count + 3'd1;
		r = '0;
		if (mp_phase == wpp_pkg::PH_DATA) begin
			mp_left = mp_left - 32'd1;
			if (32'(mp_count) < mp_bits / 8) begin
				if (mp_left == 0) mp_phase = wpp_pkg::PH_IDLE;
				return;
			end
			v = mp_shift;
			if (mp_bits / 8 == 1) v = v ^ wpp_pkg::SIGN_FLIP;
			r.kind = wpp_pkg::KIND_SAMPLE;
			r.sample = v;
			r.chan = mp_cur[15:0];
			if (mp_cur + 32'd1 >= mp_chans) begin
				r.fend = 1'b1;
				mp_cur = '0;
			end else
				mp_cur = (mp_cur + 32'd1) & 32'hFFFF;
			mp_shift = '0;
			mp_count = '0;
			if (mp_left == 0) mp_phase = wpp_pkg::PH_IDLE;
			pending_results.push_back(r);
			return;
		end
		len = wpp_pkg::is_short(mp_phase) ? 2 : 4;
		if (int'(mp_count) < len) return;
		v = (len == 2) ? (mp_shift >> 16) : mp_shift;
		mp_shift = '0;
		mp_count = '0;
		code = wpp_pkg::ERR_NONE;
		case (mp_phase)
			wpp_pkg::PH_RIFF:   if (v != wpp_pkg::ID_RIFF) code = wpp_pkg::ERR_RIFF;
			wpp_pkg::PH_WAVE:   if (v != wpp_pkg::ID_WAVE) code = wpp_pkg::ERR_WAVE;
			wpp_pkg::PH_FMT:    if (v != wpp_pkg::ID_FMT) code = wpp_pkg::ERR_FMT;
			wpp_pkg::PH_FORMAT: if (v != 32'd1) code = wpp_pkg::ERR_FORMAT;
			wpp_pkg::PH_CHANNELS: begin
				mp_chans = v; if (v == 0) code = wpp_pkg::ERR_CHANNELS;
			end
			wpp_pkg::PH_RATE: begin
				mp_rate = v; if (v == 0) code = wpp_pkg::ERR_RATE;
			end
			wpp_pkg::PH_BYTE_RATE: begin
				mp_brate = v; if (v == 0) code = wpp_pkg::ERR_BYTE_RATE0;
			end
			wpp_pkg::PH_BLOCK: begin
				mp_block = v; if (v == 0) code = wpp_pkg::ERR_BLOCK0;
			end
			wpp_pkg::PH_BITS: begin
				mp_bits = v;
				prod = 64'(mp_rate) * 64'(mp_block);
				if (v == 0) code = wpp_pkg::ERR_BITS0;
				else if (64'(mp_bits / 8) * 64'(mp_chans) != 64'(mp_block))
					code = wpp_pkg::ERR_BLOCK;
				else if (prod[31:0] != mp_brate) code = wpp_pkg::ERR_BYTE_RATE;
			end
			wpp_pkg::PH_DATA_ID: if (v != wpp_pkg::ID_DATA) code = wpp_pkg::ERR_DATA_ID;
			wpp_pkg::PH_DATA_SIZE: begin
				if (mp_block == 0 || (v % mp_block) != 0) code = wpp_pkg::ERR_MULTIPLE;
				else if (!(mp_bits inside {32'd8, 32'd16, 32'd24, 32'd32}))
					code = wpp_pkg::ERR_BITS;
				else begin
					r.kind = wpp_pkg::KIND_HEADER;
					r.nchan = mp_chans[15:0];
					r.rate = mp_rate;
					r.bits = mp_bits[5:0];
					r.frames = v / mp_block;
					mp_left = v;
					mp_cur = '0;
					mp_phase = (v == 0) ? wpp_pkg::PH_IDLE : wpp_pkg::PH_DATA;
					pending_results.push_back(r);
					return;
				end
			end
			default: ;
		endcase
		if (code != wpp_pkg::ERR_NONE) begin
			mp_phase = wpp_pkg::PH_IDLE;
			pending_results.push_back(err_result(code));
			return;
		end
		mp_phase = wpp_pkg::phase_t'(mp_phase + 4'd1);
	endtask

	// one beat into the block, with optional idle burst before it
	task automatic send_byte(logic [7:0] b, logic nf);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		new_file <= nf;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_byte(b, nf);
		@(negedge clk);
	endtask

	// 44-byte header with chosen fields; only the first upto bytes are sent
	task automatic send_header(logic [31:0] riff, logic [31:0] wave, logic [31:0] fmt,
			logic [15:0] format, logic [15:0] chans, logic [31:0] rate,
			logic [31:0] brate, logic [15:0] block, logic [15:0] bits,
			logic [31:0] did, logic [31:0] size, int upto);
		logic [7:0]  hdr [44];
		logic [31:0] rsize;
		logic [31:0] fsize;
		rsize = $urandom;
		fsize = 32'd16;
		for (int i = 0; i < 4; i++) begin
			hdr[i]      = riff[8 * i +: 8];
			hdr[4 + i]  = rsize[8 * i +: 8];
			hdr[8 + i]  = wave[8 * i +: 8];
			hdr[12 + i] = fmt[8 * i +: 8];
			hdr[16 + i] = fsize[8 * i +: 8];
			hdr[24 + i] = rate[8 * i +: 8];
			hdr[28 + i] = brate[8 * i +: 8];
			hdr[36 + i] = did[8 * i +: 8];
			hdr[40 + i] = size[8 * i +: 8];
		end
		for (int i = 0; i < 2; i++) begin
			hdr[20 + i] = format[8 * i +: 8];
			hdr[22 + i] = chans[8 * i +: 8];
			hdr[32 + i] = block[8 * i +: 8];
			hdr[34 + i] = bits[8 * i +: 8];
		end
		for (int i = 0; i < upto; i++) send_byte(hdr[i], i == 0);
	endtask

	task automatic send_good(logic [15:0] chans, logic [15:0] bits, logic [31:0] rate,
			int frames);
		logic [15:0] block;
		block = chans * (bits / 16'd8);
		send_header(wpp_pkg::ID_RIFF, wpp_pkg::ID_WAVE, wpp_pkg::ID_FMT, 16'd1, chans, rate,
			rate * {16'd0, block}, block, bits, wpp_pkg::ID_DATA,
			32'(frames) * {16'd0, block}, 44);
	endtask

	task automatic send_noise(int n);
		for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'b0);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	// compare each result beat with the oldest prediction
	initial begin
		wav_result_t e;
		wav_result_t a;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				a = {result_kind, sample_value, channel_index, frame_end, error_code,
					channel_count, sample_rate, sample_bits, frame_count};
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result exp none got %h", $time, a);
					fail_count++;
				end else begin
					e = pending_results.pop_front();
					if (e !== a) begin
						fail_count++;
						$display("%0t: mismatch exp %h got %h", $time, e, a);
					end
				end
			end
		end
	end

	// random back-pressure on the result side
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic test_directed();
		logic [15:0] bits_tab [4] = '{16'd8, 16'd16, 16'd24, 16'd32};
		foreach (bits_tab[i]) begin
			send_good(16'd2, bits_tab[i], 32'd8000, 1);
			// extreme data bytes on every width
			for (int k = 0; k < 2 * int'(bits_tab[i]) / 8; k++)
				send_byte(k[0] ? 8'hFF : 8'h00, 1'b0);
		end
		// empty data chunk, then ignored bytes
		send_good(16'd1, 16'd8, 32'd1, 0);
		send_noise(4);
		drain();
	endtask

	task automatic test_errors();
		send_header(32'h0, wpp_pkg::ID_WAVE, wpp_pkg::ID_FMT, 16'd1, 16'd1, 32'd1, 32'd1,
			16'd1, 16'd8, wpp_pkg::ID_DATA, 32'd1, 4);
		send_noise(3);
		send_header(wpp_pkg::ID_RIFF, 32'hFFFF_FFFF, wpp_pkg::ID_FMT, 16'd1, 16'd1, 32'd1,
			32'd1, 16'd1, 16'd8, wpp_pkg::ID_DATA, 32'd1, 12);
		send_header(wpp_pkg::ID_RIFF, wpp_pkg::ID_WAVE, 32'h1, 16'd1, 16'd1, 32'd1, 32'd1,
			16'd1, 16'd8, wpp_pkg::ID_DATA, 32'd1, 16);
		send_header(wpp_pkg::ID_RIFF, wpp_pkg::ID_WAVE, wpp_pkg::ID_FMT, 16'd3, 16'd1, 32'd1,
			32'd1, 16'd1, 16'd8, wpp_pkg::ID_DATA, 32'd1, 22);
		send_header(wpp_pkg::ID_RIFF, wpp_pkg::ID_WAVE, wpp_pkg::ID_FMT, 16'd1, 16'd0, 32'd1,
			32'd1, 16'd1, 16'd8, wpp_pkg::ID_DATA, 32'd1, 24);
		send_header(wpp_pkg::ID_RIFF, wpp_pkg::ID_WAVE, wpp_pkg::ID_FMT, 16'd1, 16'd1, 32'd0,
			32'd1, 16'd1, 16'd8, wpp_pkg::ID_DATA, 32'd1, 28);
		send_header(wpp_pkg::ID_RIFF, wpp_pkg::ID_WAVE, wpp_pkg::ID_FMT, 16'd1, 16'd1, 32'd1,
			32'd0, 16'd1, 16'd8, wpp_pkg::ID_DATA, 32'd1, 32);
		send_header(wpp_pkg::ID_RIFF, wpp_pkg::ID_WAVE, wpp_pkg::ID_FMT, 16'd1, 16'd1, 32'd1,
			32'd1, 16'd0, 16'd8, wpp_pkg::ID_DATA, 32'd1, 34);
		send_header(wpp_pkg::ID_RIFF, wpp_pkg::ID_WAVE, wpp_pkg::ID_FMT, 16'd1, 16'd1, 32'd1,
			32'd1, 16'd1, 16'd0, wpp_pkg::ID_DATA, 32'd1, 36);
		send_header(wpp_pkg::ID_RIFF, wpp_pkg::ID_WAVE, wpp_pkg::ID_FMT, 16'd1, 16'd2, 32'd1,
			32'd1, 16'd1, 16'd8, wpp_pkg::ID_DATA, 32'd1, 36);
		send_header(wpp_pkg::ID_RIFF, wpp_pkg::ID_WAVE, wpp_pkg::ID_FMT, 16'd1, 16'd1, 32'd5,
			32'd4, 16'd1, 16'd8, wpp_pkg::ID_DATA, 32'd1, 36);
		send_header(wpp_pkg::ID_RIFF, wpp_pkg::ID_WAVE, wpp_pkg::ID_FMT, 16'd1, 16'd1, 32'd1,
			32'd1, 16'd1, 16'd8, 32'h0, 32'd1, 40);
		send_header(wpp_pkg::ID_RIFF, wpp_pkg::ID_WAVE, wpp_pkg::ID_FMT, 16'd1, 16'd2, 32'd1,
			32'd2, 16'd2, 16'd8, wpp_pkg::ID_DATA, 32'd3, 44);
		send_header(wpp_pkg::ID_RIFF, wpp_pkg::ID_WAVE, wpp_pkg::ID_FMT, 16'd1, 16'd1, 32'd1,
			32'd1, 16'd1, 16'd12, wpp_pkg::ID_DATA, 32'd1, 44);
		// byte rate wraps modulo 2^32; extreme field values
		send_header(wpp_pkg::ID_RIFF, wpp_pkg::ID_WAVE, wpp_pkg::ID_FMT, 16'd1, 16'hFFFF,
			32'hFFFF_FFFF, 32'hFFFF_0001, 16'hFFFF, 16'd8, wpp_pkg::ID_DATA,
			32'hFFFF_FFFF, 44);
		drain();
	endtask

	task automatic test_random(int budget);
		int sent;
		int n_extra;
		logic [15:0] bits;
		sent = 0;
		while (sent < budget) begin
			case ($urandom_range(0, 9))
				0: begin send_noise(8); send_byte(8'($urandom), 1'b1); sent += 9; end
				1: begin
					send_header(($urandom_range(0, 1) != 0) ? wpp_pkg::ID_RIFF : 32'($urandom),
						wpp_pkg::ID_WAVE, wpp_pkg::ID_FMT, 16'd1, 16'($urandom_range(0, 3)),
						32'($urandom), 32'($urandom), 16'($urandom_range(0, 4)),
						16'($urandom_range(0, 40)), wpp_pkg::ID_DATA,
						32'($urandom_range(0, 16)), 44);
					sent += 44;
				end
				default: begin
					bits = 16'(8 * $urandom_range(1, 4));
					send_good(16'($urandom_range(1, 3)), bits, 32'($urandom),
						int'($urandom_range(0, 6)));
					sent += 44;
					n_extra = int'($urandom_range(0, 40));
					for (int k = 0; k < n_extra; k++) begin
						send_byte(8'($urandom), 1'b0);
						sent++;
					end
				end
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		new_file = 1'b0;
		fail_count = 0;
		idle_on = 1'b1;
		mirror_clear();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_errors();
		test_random(40);
		// sender holds off until all results are back
		drain();
		idle_on = 1'b0;
		test_random(40);
		drain();
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
